>>> src/dppt_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel to point package
// Shared constants, status codes and register indexes of the back-projection
// pipeline and its divider.
// ----------------------------------------------------------------------------
package dppt_pkg;

  localparam int unsigned ImageWidth  = 640;
  localparam int unsigned ImageHeight = 480;

  // Dividend magnitude: 17-bit centered coordinate times 24-bit depth.
  localparam int unsigned DivNumW = 41;
  localparam int unsigned DivDenW = 16;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BOUNDS  = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_CONFIG  = 3'd4;

  localparam logic [2:0] REG_ENCODING   = 3'd0;
  localparam logic [2:0] REG_BYTE_ORDER = 3'd1;
  localparam logic [2:0] REG_MIN_DEPTH  = 3'd2;
  localparam logic [2:0] REG_MAX_DEPTH  = 3'd3;
  localparam logic [2:0] REG_FOCAL_X    = 3'd4;
  localparam logic [2:0] REG_FOCAL_Y    = 3'd5;
  localparam logic [2:0] REG_CENTER_X   = 3'd6;
  localparam logic [2:0] REG_CENTER_Y   = 3'd7;

endpackage

>>> src/dppt_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, one new operand
// pair accepted per enabled cycle.
// ----------------------------------------------------------------------------
module dppt_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [dppt_pkg::DivNumW-1:0]      num_i,
  input  logic [dppt_pkg::DivDenW-1:0]      den_i,
  output logic [dppt_pkg::DivNumW-1:0]      quo_o
);

  logic [dppt_pkg::DivDenW-1:0] rem_q [dppt_pkg::DivNumW];
  logic [dppt_pkg::DivNumW-1:0] nq_q  [dppt_pkg::DivNumW];

  for (genvar s = 0; s < dppt_pkg::DivNumW; s++) begin : g_stage
    logic [dppt_pkg::DivDenW-1:0] rem_in;
    logic [dppt_pkg::DivNumW-1:0] nq_in;
    logic [dppt_pkg::DivDenW:0]   trial;
    logic                         ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
    end

    // The dividend bits shift out at the top while quotient bits shift in.
    assign trial = {rem_in, nq_in[dppt_pkg::DivNumW-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? dppt_pkg::DivDenW'(trial - {1'b0, den_i})
                       : trial[dppt_pkg::DivDenW-1:0];
        nq_q[s]  <= {nq_in[dppt_pkg::DivNumW-2:0], ge};
      end
    end
  end

  assign quo_o = nq_q[dppt_pkg::DivNumW-1];

endmodule

>>> src/depth_pixel_to_point_unit.sv
// ----------------------------------------------------------------------------
// Depth pixel to point unit
// Decodes a depth pixel and back-projects it through a pinhole camera model.
// ----------------------------------------------------------------------------
// Input transactions (in_valid_i/in_ready_o) carry pixel column, row and the
// raw depth word. Each produces exactly one output transaction
// (out_valid_o/out_ready_i) with X, Y, Z and a status code; on a non-zero
// status the point fields are zero.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write them only while the pipeline is empty (not enforced).
// An item passes four stages of decode, depth scaling, checks and multiply,
// 41 stages of the bit-per-stage divider, and the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// All stages move together: when the receiver stalls with a result waiting,
// in_ready_o drops and every item in flight holds its place.
// Reset clears all stage valid bits and loads the default calibration.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [11:0] pixel_u_i,
  input  logic signed [11:0] pixel_v_i,
  input  logic [31:0]        raw_depth_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [23:0]        point_z_o,
  output logic [2:0]         status_o
);

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic        neg_x;
    logic        neg_y;
    logic [23:0] z;
  } meta_t;

  logic        encoding_q, byte_order_q;
  logic [15:0] min_depth_q, max_depth_q, focal_x_q, focal_y_q;
  logic [15:0] center_x_q, center_y_q;

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q   <= 1'b0;
      byte_order_q <= 1'b0;
      min_depth_q  <= 16'd200;
      max_depth_q  <= 16'd10000;
      focal_x_q    <= 16'd9600;
      focal_y_q    <= 16'd9600;
      center_x_q   <= 16'd5120;
      center_y_q   <= 16'd3840;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dppt_pkg::REG_ENCODING:   encoding_q   <= cfg_wdata_i[0];
        dppt_pkg::REG_BYTE_ORDER: byte_order_q <= cfg_wdata_i[0];
        dppt_pkg::REG_MIN_DEPTH:  min_depth_q  <= cfg_wdata_i;
        dppt_pkg::REG_MAX_DEPTH:  max_depth_q  <= cfg_wdata_i;
        dppt_pkg::REG_FOCAL_X:    focal_x_q    <= cfg_wdata_i;
        dppt_pkg::REG_FOCAL_Y:    focal_y_q    <= cfg_wdata_i;
        dppt_pkg::REG_CENTER_X:   center_x_q   <= cfg_wdata_i;
        dppt_pkg::REG_CENTER_Y:   center_y_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage 1: byte order, field split, bounds and invalid-depth checks, centering.
  logic [31:0] bits;
  logic [15:0] mm;
  logic [7:0]  exp_raw;
  logic [22:0] frac;
  logic        bounds_bad, depth_bad;
  logic signed [17:0] du_d, dv_d;

  assign bits = byte_order_q ? {raw_depth_i[7:0], raw_depth_i[15:8],
                                raw_depth_i[23:16], raw_depth_i[31:24]}
                             : raw_depth_i;
  assign mm   = byte_order_q ? {raw_depth_i[7:0], raw_depth_i[15:8]}
                             : raw_depth_i[15:0];
  assign exp_raw = bits[30:23];
  assign frac    = bits[22:0];

  assign bounds_bad = pixel_u_i < 0 || pixel_v_i < 0 ||
                      $unsigned(pixel_u_i) >= 12'(dppt_pkg::ImageWidth) ||
                      $unsigned(pixel_v_i) >= 12'(dppt_pkg::ImageHeight);
  assign depth_bad  = encoding_q ? (exp_raw == 8'hFF || bits[31] ||
                                    (exp_raw == 8'd0 && frac == 23'd0))
                                 : (mm == 16'd0);

  assign du_d = 18'(signed'({{2{pixel_u_i[11]}}, pixel_u_i, 4'd0}))
              - 18'(signed'(center_x_q));
  assign dv_d = 18'(signed'({{2{pixel_v_i[11]}}, pixel_v_i, 4'd0}))
              - 18'(signed'(center_y_q));

  logic               s1_v_q;
  logic [2:0]         s1_stat_q;
  logic [15:0]        s1_mm_q;
  logic [23:0]        s1_man_q;
  logic [7:0]         s1_exp_q;
  logic signed [17:0] s1_du_q, s1_dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_stat_q <= bounds_bad ? dppt_pkg::ST_BOUNDS
                 : depth_bad  ? dppt_pkg::ST_INVALID : dppt_pkg::ST_OK;
      s1_mm_q   <= mm;
      s1_man_q  <= (exp_raw == 8'd0) ? {1'b0, frac} : {1'b1, frac};
      s1_exp_q  <= (exp_raw == 8'd0) ? 8'd1 : exp_raw;
      s1_du_q   <= du_d;
      s1_dv_q   <= dv_d;
    end
  end

  // Stage 2: mantissa times 256000.
  logic               s2_v_q;
  logic [2:0]         s2_stat_q;
  logic [15:0]        s2_mm_q;
  logic [41:0]        s2_p_q;
  logic [7:0]         s2_exp_q;
  logic signed [17:0] s2_du_q, s2_dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_stat_q <= s1_stat_q;
      s2_mm_q   <= s1_mm_q;
      s2_p_q    <= 42'(s1_man_q) * 42'd256000;
      s2_exp_q  <= s1_exp_q;
      s2_du_q   <= s1_du_q;
      s2_dv_q   <= s1_dv_q;
    end
  end

  // Stage 3: exponent shift with cap, configuration and range checks.
  logic signed [9:0] sh;
  logic [8:0]        rsh;
  logic [63:0]       shl, shr;
  logic [24:0]       zf, z25;
  logic              cfg_bad, range_bad;
  logic [2:0]        s3_stat_d;

  assign sh  = 10'(signed'({2'b00, s2_exp_q})) - 10'sd150;
  assign rsh = 9'(-sh);
  assign shl = {22'd0, s2_p_q} << sh[4:0];
  assign shr = {22'd0, s2_p_q} >> rsh[5:0];

  always_comb begin
    if (sh > 10'sd20) begin
      zf = 25'h1000000;
    end else if (sh >= 10'sd0) begin
      zf = (shl > 64'h1000000) ? 25'h1000000 : shl[24:0];
    end else if (rsh >= 9'd64) begin
      zf = '0;
    end else begin
      zf = (shr > 64'h1000000) ? 25'h1000000 : shr[24:0];
    end
  end

  assign z25       = encoding_q ? zf : {1'b0, s2_mm_q, 8'd0};
  assign cfg_bad   = min_depth_q == 16'd0 || max_depth_q < min_depth_q ||
                     focal_x_q == 16'd0 || focal_y_q == 16'd0;
  assign range_bad = z25 < {1'b0, min_depth_q, 8'd0} ||
                     z25 > {1'b0, max_depth_q, 8'd0};
  assign s3_stat_d = (s2_stat_q != dppt_pkg::ST_OK) ? s2_stat_q
                   : cfg_bad   ? dppt_pkg::ST_CONFIG
                   : range_bad ? dppt_pkg::ST_RANGE : dppt_pkg::ST_OK;

  logic               s3_v_q;
  logic [2:0]         s3_stat_q;
  logic [23:0]        s3_z_q;
  logic signed [17:0] s3_du_q, s3_dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_stat_q <= s3_stat_d;
      s3_z_q    <= (s3_stat_d == dppt_pkg::ST_OK) ? z25[23:0] : 24'd0;
      s3_du_q   <= s2_du_q;
      s3_dv_q   <= s2_dv_q;
    end
  end

  // Stage 4: magnitude products for the dividers.
  logic [16:0] mag_u, mag_v;
  assign mag_u = s3_du_q[17] ? 17'(-s3_du_q) : s3_du_q[16:0];
  assign mag_v = s3_dv_q[17] ? 17'(-s3_dv_q) : s3_dv_q[16:0];

  meta_t                         s4_q;
  logic [dppt_pkg::DivNumW-1:0]  prod_x_q, prod_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (adv) begin
      s4_q <= '{valid: s3_v_q, status: s3_stat_q, neg_x: s3_du_q[17],
                neg_y: s3_dv_q[17], z: s3_z_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_x_q <= dppt_pkg::DivNumW'(mag_u) * dppt_pkg::DivNumW'(s3_z_q);
      prod_y_q <= dppt_pkg::DivNumW'(mag_v) * dppt_pkg::DivNumW'(s3_z_q);
    end
  end

  // Divider stages with matching side-band pipeline.
  logic [dppt_pkg::DivNumW-1:0] quo_x, quo_y;

  dppt_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (prod_x_q),
    .den_i (focal_x_q),
    .quo_o (quo_x)
  );

  dppt_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (prod_y_q),
    .den_i (focal_y_q),
    .quo_o (quo_y)
  );

  meta_t meta_q [dppt_pkg::DivNumW];

  for (genvar s = 0; s < dppt_pkg::DivNumW; s++) begin : g_meta
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        meta_q[s] <= '0;
      end else if (adv) begin
        meta_q[s] <= (s == 0) ? s4_q : meta_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  function automatic logic [31:0] sat_signed(logic neg, logic [dppt_pkg::DivNumW-1:0] mag);
    logic [31:0] res;
    if (neg) begin
      res = (mag > dppt_pkg::DivNumW'(33'h80000000)) ? 32'h80000000 : 32'(-mag);
    end else begin
      res = (mag > dppt_pkg::DivNumW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : mag[31:0];
    end
    return res;
  endfunction

  // Output register.
  meta_t last;
  logic  last_ok;
  assign last    = meta_q[dppt_pkg::DivNumW-1];
  assign last_ok = last.status == dppt_pkg::ST_OK;

  logic        out_v_q;
  logic [31:0] px_q, py_q;
  logic [23:0] pz_q;
  logic [2:0]  st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= last_ok ? sat_signed(last.neg_x, quo_x) : 32'd0;
      py_q <= last_ok ? sat_signed(last.neg_y, quo_y) : 32'd0;
      pz_q <= last_ok ? last.z : 24'd0;
      st_q <= last.status;
    end
  end

  assign out_valid_o = out_v_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign point_z_o   = pz_q;
  assign status_o    = st_q;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dppt_pkg::ST_OK |->
      point_x_o == 32'd0 && point_y_o == 32'd0 && point_z_o == 24'd0)
    else $error("non-ok result carries a nonzero point");

  a_ok_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dppt_pkg::ST_OK |-> point_z_o != 24'd0)
    else $error("accepted result has zero depth");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(meta_q[0]) && $stable(s4_q))
    else $error("pipeline moved during a stall");
`endif

endmodule
